>>> rtl/core/assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SHB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SHB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/shb_pkg.sv
`default_nettype none

package shb_pkg;

  localparam int HASH_BITS   = 32;
  localparam int INDEX_BITS  = 16;
  localparam int COUNT_BITS  = 17;
  localparam int GROUP_BYTES = 12;
  localparam int TAIL_BYTES  = GROUP_BYTES - 1;
  localparam int GROUP_BITS  = 8 * TAIL_BYTES;

  localparam logic [HASH_BITS-1:0]  GOLDEN_WORD = 32'h9e3779b9;
  localparam logic [COUNT_BITS-1:0] MAX_BUCKETS = 17'h10000;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // one unit of work for the mixer: words to add, then a full mix
  typedef struct packed {
    logic                 is_final;
    logic [HASH_BITS-1:0] a_add;
    logic [HASH_BITS-1:0] b_add;
    logic [HASH_BITS-1:0] c_add;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/core/shb_in_if.sv
`default_nettype none

interface shb_in_if;
  import shb_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/shb_out_if.sv
`default_nettype none

interface shb_out_if;
  import shb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [HASH_BITS-1:0]  hash_value;
  logic [INDEX_BITS-1:0] bucket_index;

  modport source (output valid, output hash_value, output bucket_index, input ready);
  modport sink   (input valid, input hash_value, input bucket_index, output ready);
endinterface

`default_nettype wire

>>> rtl/core/shb_cfg_if.sv
`default_nettype none

interface shb_cfg_if;
  import shb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] bucket_count;

  modport source (output valid, output bucket_count, input ready);
  modport sink   (input valid, input bucket_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/string_hash_to_bucket.sv
// string_hash_to_bucket: lookup2 hash (initial value 0) of a name streamed one
// beat per byte, reduced to a bucket index. the front stage takes one beat per
// cycle while it is ready, packs bytes into 12-byte groups and posts a mix job
// per full group and one final job per name into a short job queue; the back
// stage adds the group words of each job and then runs the mix as nine steps.
// the front stalls when the queue is full and while it posts the final job of
// a name that ends exactly on a group boundary. at the end of a name the back
// stage also runs a restoring divider for the modulo. results wait in an
// output register, so the front keeps taking beats while a result is not yet
// taken, until the job queue fills. the user must write bucket_count through
// cfg only while the block is idle; the block itself does not enforce this.
// values above 65536 act as 65536 and a count of 0 gives index 0.
`default_nettype none

module string_hash_to_bucket #(
  parameter int QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  shb_in_if.sink    name_bytes,
  shb_out_if.source result,
  shb_cfg_if.sink   cfg
);
  import shb_pkg::*;

  // configuration register, always ready
  logic [COUNT_BITS-1:0] bucket_count;
  // clamped count seen by the divider
  logic [COUNT_BITS-1:0] count_eff;

  // job queue between front and back
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t q_job;
  job_t q_head;

  assign cfg.ready = 1'b1;
  assign count_eff = (bucket_count > MAX_BUCKETS) ? MAX_BUCKETS : bucket_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= '0;
    end else if (cfg.valid) begin
      bucket_count <= cfg.bucket_count;
    end
  end

  // byte packing and job issue
  shb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .name_bytes (name_bytes),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  // decouples the byte side from the mixer
  shb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // mixer, divider and output register
  shb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_head       (q_head),
    .bucket_count (count_eff),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> rtl/core/shb_front.sv
`default_nettype none
`include "assert_macros.svh"

module shb_front (
  input  logic         clk,
  input  logic         rst,
  shb_in_if.sink       name_bytes,
  input  logic         q_full,
  output logic         q_push,
  output shb_pkg::job_t q_job
);
  import shb_pkg::*;

  logic [GROUP_BITS-1:0] group_bytes;
  logic [3:0]            group_fill;
  logic [HASH_BITS-1:0]  total_length;
  logic                  pending_final;

  logic [GROUP_BITS-1:0] group_ins;
  logic [HASH_BITS-1:0]  len_next;
  logic                  accept;
  logic                  group_done;

  assign name_bytes.ready = !pending_final && !q_full;
  assign accept           = name_bytes.valid && name_bytes.ready;
  assign len_next         = total_length + HASH_BITS'(name_bytes.byte_valid);
  assign group_done       = name_bytes.byte_valid && (group_fill == 4'(TAIL_BYTES));

  // pending bytes with the current byte dropped in at the fill position
  always_comb begin
    group_ins = group_bytes;
    for (int i = 0; i < TAIL_BYTES; i++) begin
      if (name_bytes.byte_valid && (group_fill == 4'(i))) begin
        group_ins[8*i +: 8] = name_bytes.data_byte;
      end
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_job  = '0;
    if (pending_final) begin
      // name ended on a group boundary: empty tail, length only
      q_push         = !q_full;
      q_job.is_final = 1'b1;
      q_job.c_add    = total_length;
    end else if (accept && group_done) begin
      q_push      = 1'b1;
      q_job.a_add = group_bytes[31:0];
      q_job.b_add = group_bytes[63:32];
      q_job.c_add = {name_bytes.data_byte, group_bytes[87:64]};
    end else if (accept && name_bytes.last) begin
      q_push         = 1'b1;
      q_job.is_final = 1'b1;
      q_job.a_add    = group_ins[31:0];
      q_job.b_add    = group_ins[63:32];
      q_job.c_add    = len_next + {group_ins[87:64], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes   <= '0;
      group_fill    <= '0;
      total_length  <= '0;
      pending_final <= 1'b0;
    end else if (pending_final) begin
      if (!q_full) begin
        pending_final <= 1'b0;
        group_bytes   <= '0;
        group_fill    <= '0;
        total_length  <= '0;
      end
    end else if (accept) begin
      if (group_done) begin
        group_bytes   <= '0;
        group_fill    <= '0;
        total_length  <= len_next;
        pending_final <= name_bytes.last;
      end else if (name_bytes.last) begin
        group_bytes  <= '0;
        group_fill   <= '0;
        total_length <= '0;
      end else begin
        group_bytes  <= group_ins;
        group_fill   <= group_fill + 4'(name_bytes.byte_valid);
        total_length <= len_next;
      end
    end
  end

  `SHB_ASSERT_IMPL(a_fill_range, 1'b1, group_fill <= 4'(TAIL_BYTES))
  `SHB_ASSERT_NEXT(a_pend_clears, pending_final && !q_full,
                   !pending_final && group_fill == '0 && total_length == '0)

endmodule

`default_nettype wire

>>> rtl/core/shb_fifo.sv
`default_nettype none
`include "assert_macros.svh"

module shb_fifo #(
  parameter int DEPTH = shb_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  shb_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output shb_pkg::job_t head
);
  import shb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SHB_ASSERT_IMPL(a_no_overflow, push && !pop, count < CW'(DEPTH))
  `SHB_ASSERT_IMPL(a_no_underflow, pop, count != '0)

endmodule

`default_nettype wire

>>> rtl/core/shb_back.sv
`default_nettype none
`include "assert_macros.svh"

module shb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  shb_pkg::job_t                  q_head,
  input  logic [shb_pkg::COUNT_BITS-1:0] bucket_count,
  shb_out_if.source                      result
);
  import shb_pkg::*;

  localparam int MIX_STEPS = 9;
  localparam int DIV_STEPS = HASH_BITS;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {S_IDLE, S_MIX, S_DIV, S_DONE} state_t;
  typedef enum logic [1:0] {LANE_A, LANE_B, LANE_C} lane_t;

  state_t                state;
  lane_t                 lane;
  logic [3:0]            step;
  logic                  is_final;
  logic [HASH_BITS-1:0]  mix_a;
  logic [HASH_BITS-1:0]  mix_b;
  logic [HASH_BITS-1:0]  mix_c;
  logic [HASH_BITS-1:0]  div_word;
  logic [DIV_CW-1:0]     div_count;
  logic [INDEX_BITS-1:0] rem;
  logic                  out_valid;
  logic [HASH_BITS-1:0]  out_hash;
  logic [INDEX_BITS-1:0] out_index;

  logic [4:0]            sh;
  logic [HASH_BITS-1:0]  new_a;
  logic [HASH_BITS-1:0]  new_b;
  logic [HASH_BITS-1:0]  new_c;
  logic [COUNT_BITS-1:0] trial;
  logic [INDEX_BITS-1:0] rem_next;
  logic                  out_free;

  // shift amount of each mix step
  function automatic logic [4:0] mix_shift(input logic [3:0] s);
    logic [4:0] r;
    case (s)
      4'd0:    r = 5'd13;
      4'd1:    r = 5'd8;
      4'd2:    r = 5'd13;
      4'd3:    r = 5'd12;
      4'd4:    r = 5'd16;
      4'd5:    r = 5'd5;
      4'd6:    r = 5'd3;
      4'd7:    r = 5'd10;
      default: r = 5'd15;
    endcase
    return r;
  endfunction

  assign sh    = mix_shift(step);
  assign new_a = (mix_a - mix_b - mix_c) ^ (mix_c >> sh);
  assign new_b = (mix_b - mix_c - mix_a) ^ (mix_a << sh);
  assign new_c = (mix_c - mix_a - mix_b) ^ (mix_b >> sh);

  // restoring division, one quotient bit per cycle
  assign trial    = {rem, div_word[HASH_BITS-1]};
  assign rem_next = (trial >= bucket_count) ? INDEX_BITS'(trial - bucket_count)
                                            : trial[INDEX_BITS-1:0];

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || result.ready;

  assign result.valid        = out_valid;
  assign result.hash_value   = out_hash;
  assign result.bucket_index = out_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lane      <= LANE_A;
      step      <= '0;
      is_final  <= 1'b0;
      mix_a     <= GOLDEN_WORD;
      mix_b     <= GOLDEN_WORD;
      mix_c     <= '0;
      div_count <= '0;
      out_valid <= 1'b0;
    end else begin
      // in S_DONE a taken result is replaced by the next one below
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            mix_a    <= mix_a + q_head.a_add;
            mix_b    <= mix_b + q_head.b_add;
            mix_c    <= mix_c + q_head.c_add;
            is_final <= q_head.is_final;
            step     <= '0;
            lane     <= LANE_A;
            state    <= S_MIX;
          end
        end
        S_MIX: begin
          unique case (lane)
            LANE_A: begin
              mix_a <= new_a;
              lane  <= LANE_B;
            end
            LANE_B: begin
              mix_b <= new_b;
              lane  <= LANE_C;
            end
            LANE_C: begin
              mix_c <= new_c;
              lane  <= LANE_A;
            end
            default: lane <= LANE_A;
          endcase
          step <= step + 1'b1;
          if (step == 4'(MIX_STEPS - 1)) begin
            if (is_final) begin
              div_word  <= new_c;
              rem       <= '0;
              div_count <= '0;
              state     <= S_DIV;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          rem       <= rem_next;
          div_word  <= div_word << 1;
          div_count <= div_count + 1'b1;
          if (div_count == DIV_CW'(DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_hash  <= mix_c;
            out_index <= (bucket_count == '0) ? '0 : rem;
            mix_a     <= GOLDEN_WORD;
            mix_b     <= GOLDEN_WORD;
            mix_c     <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SHB_ASSERT_IMPL(a_index_range, result.valid && bucket_count != '0,
                   {1'b0, result.bucket_index} < bucket_count)

endmodule

`default_nettype wire

>>> tb/string_hash_to_bucket_tb.sv
`timescale 1ns / 100ps

module string_hash_to_bucket_tb;
  import shb_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PHASES         = 8;
  localparam int BEATS_PER_PHASE = 160;
  localparam int DIRECTED_ROWS  = 19;

  // one directed beat, with an optional hand-typed bucket index
  typedef struct packed {
    logic [7:0]            data;
    logic                  bval;
    logic                  lst;
    logic                  has_idx;
    logic [INDEX_BITS-1:0] idx;
  } stim_row_t;

  typedef struct packed {
    logic [HASH_BITS-1:0]  hash;
    logic [INDEX_BITS-1:0] bucket_idx;
  } bucket_result_t;

  logic clk;
  logic rst;

  shb_in_if  name_bytes_if ();
  shb_out_if result_if ();
  shb_cfg_if cfg_if ();

  string_hash_to_bucket dut (
    .clk        (clk),
    .rst        (rst),
    .name_bytes (name_bytes_if),
    .result     (result_if),
    .cfg        (cfg_if)
  );

  // hash state of the name in flight, kept alongside the block
  logic [HASH_BITS-1:0]  acc_a;
  logic [HASH_BITS-1:0]  acc_b;
  logic [HASH_BITS-1:0]  acc_c;
  logic [7:0]            held_bytes [0:TAIL_BYTES-1];
  int                    held_count;
  logic [HASH_BITS-1:0]  name_length;
  logic [COUNT_BITS-1:0] bucket_cfg;

  // hashes and indexes still owed by the block, oldest first
  bucket_result_t owed_results [$];

  stim_row_t directed_rows [0:DIRECTED_ROWS-1];

  int err_count;
  int cycle_count;
  int send_gap_pct;
  int recv_stall_pct;
  int random_items;
  bit pressure_done;

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // lookup2 model
  // ---------------------------------------------------------------------------

  // the nine-step lookup2 mix over the three words
  function automatic logic [95:0] lookup2_mix(input logic [31:0] a_in,
                                              input logic [31:0] b_in,
                                              input logic [31:0] c_in);
    logic [31:0] a, b, c;
    a = a_in;
    b = b_in;
    c = c_in;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return {a, b, c};
  endfunction

  task automatic clear_name_state();
    acc_a       = GOLDEN_WORD;
    acc_b       = GOLDEN_WORD;
    acc_c       = '0;
    held_count  = 0;
    name_length = '0;
    for (int i = 0; i < TAIL_BYTES; i++) held_bytes[i] = 8'h00;
  endtask

  // advance the name hash by one accepted beat; a last beat yields a result
  task automatic lookup2_step(input logic [7:0] d, input logic bv, input logic lst,
                              output bit emitted, output bucket_result_t res);
    logic [31:0] divisor;
    logic [31:0] rem;
    emitted = 1'b0;
    res     = '0;
    if (bv) begin
      name_length = name_length + 1;
      if (held_count == TAIL_BYTES) begin
        // twelfth byte: the group is mixed right away, even on a last beat
        acc_a = acc_a + {held_bytes[3], held_bytes[2], held_bytes[1], held_bytes[0]};
        acc_b = acc_b + {held_bytes[7], held_bytes[6], held_bytes[5], held_bytes[4]};
        acc_c = acc_c + {d, held_bytes[10], held_bytes[9], held_bytes[8]};
        {acc_a, acc_b, acc_c} = lookup2_mix(acc_a, acc_b, acc_c);
        held_count = 0;
        for (int i = 0; i < TAIL_BYTES; i++) held_bytes[i] = 8'h00;
      end else begin
        held_bytes[held_count] = d;
        held_count++;
      end
    end
    if (lst) begin
      // fold in the length and the tail; unused tail bytes are zero
      acc_c = acc_c + name_length;
      acc_a = acc_a + {held_bytes[3], held_bytes[2], held_bytes[1], held_bytes[0]};
      acc_b = acc_b + {held_bytes[7], held_bytes[6], held_bytes[5], held_bytes[4]};
      acc_c = acc_c + {held_bytes[10], held_bytes[9], held_bytes[8], 8'h00};
      {acc_a, acc_b, acc_c} = lookup2_mix(acc_a, acc_b, acc_c);
      // counts above 65536 act as 65536, zero gives index 0
      divisor = (bucket_cfg > MAX_BUCKETS) ? {15'd0, MAX_BUCKETS} : {15'd0, bucket_cfg};
      rem = (divisor == 0) ? 32'd0 : (acc_c % divisor);
      res.hash       = acc_c;
      res.bucket_idx = rem[INDEX_BITS-1:0];
      emitted = 1'b1;
      clear_name_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    err_count++;
  endtask

  // every result beat is held against the oldest owed result
  always @(posedge clk) begin : result_check
    bucket_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with nothing owed, hash", result_if.hash_value, 32'd0);
      end else begin
        want = owed_results.pop_front();
        if (result_if.hash_value !== want.hash)
          report_mismatch("hash_value", result_if.hash_value, want.hash);
        if (result_if.bucket_index !== want.bucket_idx)
          report_mismatch("bucket_index", {16'd0, result_if.bucket_index},
                          {16'd0, want.bucket_idx});
      end
    end
  end

  // receiver: ready drops in recv_stall_pct of the cycles
  always @(posedge clk) begin
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // drive one beat; valid stays high after the handshake so back-to-back beats
  // never lower and raise it in the same step
  task automatic send_beat(input logic [7:0] d, input logic bv, input logic lst,
                           input logic has_idx, input logic [INDEX_BITS-1:0] idx);
    bit             emitted;
    bucket_result_t res;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      name_bytes_if.valid <= 1'b0;
      @(posedge clk);
    end
    name_bytes_if.valid      <= 1'b1;
    name_bytes_if.data_byte  <= d;
    name_bytes_if.byte_valid <= bv;
    name_bytes_if.last       <= lst;
    @(posedge clk);
    while (!name_bytes_if.ready) @(posedge clk);
    lookup2_step(d, bv, lst, emitted, res);
    if (emitted) begin
      if (has_idx) res.bucket_idx = idx;
      owed_results.push_back(res);
    end
  endtask

  // stop sending, wait out every owed result, then let the block settle
  task automatic drain_names();
    name_bytes_if.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [COUNT_BITS-1:0] value);
    cfg_if.valid        <= 1'b1;
    cfg_if.bucket_count <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    bucket_cfg = value;
  endtask

  // one well-formed name of random content, with an occasional idle beat
  // mixed in; lengths lean short, with group boundaries and some long names
  task automatic send_random_name();
    int pick;
    int len;
    bit end_marker;
    pick = $urandom_range(99);
    if (pick < 10)      len = 0;
    else if (pick < 25) len = 12 * $urandom_range(1, 3);
    else if (pick < 30) len = $urandom_range(36, 80);
    else                len = $urandom_range(1, 23);
    end_marker = (len == 0) ? 1'b1 : 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      // idle beats carry junk bytes the block must ignore
      if ($urandom_range(99) < 8) begin
        send_beat(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
        random_items++;
      end
      send_beat(8'($urandom_range(255)), 1'b1, !end_marker && (i == len - 1), 1'b0, '0);
      random_items++;
    end
    if (end_marker) begin
      send_beat(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
      random_items++;
    end
  endtask

  function automatic logic [COUNT_BITS-1:0] phase_bucket_count(input int phase);
    case (phase)
      0:       return 17'd1;
      1:       return MAX_BUCKETS;
      2:       return 17'h1ffff;          // oversized, acts as 65536
      3:       return 17'd65535;
      4:       return COUNT_BITS'($urandom_range(131071));
      5:       return COUNT_BITS'($urandom_range(2, 1000));
      6:       return 17'd0;
      default: return COUNT_BITS'($urandom_range(1, 65536));
    endcase
  endfunction

  initial begin
    int phase_start;

    clk = 1'b0;
    rst = 1'b1;
    name_bytes_if.valid      = 1'b0;
    name_bytes_if.data_byte  = 8'h00;
    name_bytes_if.byte_valid = 1'b0;
    name_bytes_if.last       = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.bucket_count      = '0;
    result_if.ready          = 1'b0;
    err_count      = 0;
    cycle_count    = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_items   = 0;
    pressure_done  = 1'b0;
    bucket_cfg     = '0;
    clear_name_state();

    // bucket count is 0 out of reset, so every directed index is 0
    directed_rows = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000},   // empty name
      '{8'haa, 1'b0, 1'b0, 1'b0, 16'h0000},   // idle beat, byte ignored
      '{8'h00, 1'b1, 1'b1, 1'b1, 16'h0000},   // one zero byte
      '{8'hff, 1'b1, 1'b1, 1'b1, 16'h0000},   // one all-ones byte
      // twelve bytes, last on the twelfth: mixed group, empty tail
      '{8'hff, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h7f, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h01, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'hfe, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h55, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'haa, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'hff, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'hff, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'hff, 1'b1, 1'b1, 1'b1, 16'h0000},
      // one byte, an idle beat inside the name, then the end marker
      '{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'hc3, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{8'h00, 1'b0, 1'b1, 1'b1, 16'h0000}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed beats, no idling on either side
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_beat(directed_rows[i].data, directed_rows[i].bval, directed_rows[i].lst,
                directed_rows[i].has_idx, directed_rows[i].idx);

    // random phases: new bucket count and idling pattern each time
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_names();
      write_bucket_count(phase_bucket_count(phase));
      case (phase % 4)
        0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_gap_pct = 72; recv_stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  recv_stall_pct = 72; end
        default: begin send_gap_pct = 11; recv_stall_pct = 11; end
      endcase
      phase_start = random_items;
      while (random_items < phase_start + BEATS_PER_PHASE) begin
        send_random_name();
        // once mid-run, hold the sender until the block has caught up
        if (phase == 2 && !pressure_done && random_items >= phase_start + 85) begin
          pressure_done = 1'b1;
          name_bytes_if.valid <= 1'b0;
          while (owed_results.size() != 0) @(posedge clk);
          @(posedge clk);
        end
      end
    end

    drain_names();
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/shb_pkg.sv
rtl/core/shb_in_if.sv
rtl/core/shb_out_if.sv
rtl/core/shb_cfg_if.sv
rtl/core/shb_front.sv
rtl/core/shb_fifo.sv
rtl/core/shb_back.sv
rtl/core/string_hash_to_bucket.sv
tb/string_hash_to_bucket_tb.sv
